// ===== rtl/tnd_pkg.sv =====
// ----------------------------------------------------------------------------
// tnd_pkg
// Shared constants and types of the text normalizer with duplicate-word
// removal: character codes, token kinds and the token passed from the front
// end to the back end.
// ----------------------------------------------------------------------------
package tnd_pkg;

	localparam int MAX_WORD_DEFAULT = 32;
	localparam int QUEUE_DEPTH      = 4;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CASE_OFS = 8'h20;

	typedef enum logic [1:0] {
		TK_NONE  = 2'd0,
		TK_CHAR  = 2'd1,
		TK_SPACE = 2'd2
	} tnd_kind_t;

	typedef struct packed {
		tnd_kind_t   kind;
		logic [7:0]  ch;
		logic        last;
	} tnd_tok_t;

endpackage

// ===== rtl/tnd_if.sv =====
// ----------------------------------------------------------------------------
// tnd_if
// Valid/ready channels of the normalizer: raw text bytes in, normalized
// result characters out.
// ----------------------------------------------------------------------------
interface tnd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       in_last;

	modport source (output valid, output in_char, output in_last, input ready);
	modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface tnd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       is_char;
	logic       truncated;
	logic       out_last;

	modport source (output valid, output out_char, output is_char, output truncated,
		output out_last, input ready);
	modport sink   (input valid, input out_char, input is_char, input truncated,
		input out_last, output ready);
endinterface

// ===== rtl/text_normalize_dedup_words_top.sv =====
// ----------------------------------------------------------------------------
// text_normalize_dedup_words_top
// Streaming text normalizer that drops consecutive duplicate words.
// ----------------------------------------------------------------------------
// Bytes enter a QDEPTH-deep token queue at one per cycle while it has room.
// The word engine behind it reads the last emitted word from RAM and then
// compares and stores for each word character, passes through its finish
// step on a space or text end that sends nothing, and on a sent word sends
// the separating space, if one is due, and then each character. This pacing
// comes from the registered read of the two word RAM banks and the single
// result register, which holds a result until it is taken while the queue
// keeps taking bytes. No clearing pass follows reset.
module text_normalize_dedup_words_top import tnd_pkg::*; #(
	parameter int MAX_WORD = MAX_WORD_DEFAULT,
	parameter int QDEPTH   = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	tnd_in_if.sink    text,
	tnd_out_if.source words
);

	tnd_tok_t tok;
	logic     tok_valid;
	logic     tok_ready;

	tnd_front #(.DEPTH(QDEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text),
		.tok       (tok),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready)
	);

	tnd_back #(.MAX_WORD(MAX_WORD)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (tok),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.words     (words)
	);

`ifndef SYNTHESIS
	// a queued token is never lost while the engine is busy
	a_tok_held: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid)
		else $error("queued token vanished");

	// a bare end marker closes the text and carries nothing else
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		words.valid && !words.is_char |-> words.out_last && !words.truncated &&
		words.out_char == CH_NUL)
		else $error("malformed end marker");

	// a separating space never belongs to a cut word and never ends the text
	a_space: assert property (@(posedge clk) disable iff (!arst_n)
		words.valid && words.out_char == CH_SPACE |-> words.is_char &&
		!words.truncated && !words.out_last)
		else $error("bad separator transfer");
`endif

endmodule

// ===== rtl/tnd_ram.sv =====
// ----------------------------------------------------------------------------
// tnd_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module tnd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/tnd_front.sv =====
// ----------------------------------------------------------------------------
// tnd_front
// Accepts text bytes, classifies them (dropped, word character, space),
// normalizes word characters and queues the resulting tokens for the back end.
// ----------------------------------------------------------------------------
module tnd_front import tnd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	tnd_in_if.sink   text,
	output tnd_tok_t tok,
	output logic     tok_valid,
	input  logic     tok_ready
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tnd_tok_t      q_mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	tnd_tok_t      new_tok;
	logic          push;
	logic          pop;

	always_comb begin
		new_tok.kind = TK_NONE;
		new_tok.ch   = text.in_char;
		new_tok.last = text.in_last;
		if (text.in_char >= CH_SPACE && text.in_char <= CH_TILDE) begin
			if (text.in_char == CH_SPACE) begin
				new_tok.kind = TK_SPACE;
			end else begin
				new_tok.kind = TK_CHAR;
				if (text.in_char >= CH_UC_A && text.in_char <= CH_UC_Z) begin
					new_tok.ch = text.in_char + CASE_OFS;
				end else if (!((text.in_char >= CH_LC_A && text.in_char <= CH_LC_Z) ||
					(text.in_char >= CH_0 && text.in_char <= CH_9))) begin
					new_tok.ch = CH_COMMA;
				end
			end
		end
	end

	assign text.ready = (count_q != CW'(DEPTH));
	// dropped bytes only need a token when they close the text
	assign push      = text.valid && text.ready && (new_tok.kind != TK_NONE || text.in_last);
	assign tok_valid = (count_q != '0);
	assign tok       = q_mem_q[rd_ptr_q];
	assign pop       = tok_valid && tok_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= new_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/tnd_back.sv =====
// ----------------------------------------------------------------------------
// tnd_back
// Word engine: collects word characters into one RAM bank, compares them on
// the fly with the last emitted word in the other bank, and streams a word
// that differs to the result register. Banks swap roles instead of copying.
// ----------------------------------------------------------------------------
module tnd_back import tnd_pkg::*; #(
	parameter int MAX_WORD = MAX_WORD_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  tnd_tok_t tok,
	input  logic     tok_valid,
	output logic     tok_ready,
	tnd_out_if.source words
);

	localparam int LW = $clog2(MAX_WORD + 1);
	localparam int IW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_CMP  = 6'b000010,
		ST_FIN  = 6'b000100,
		ST_SPC  = 6'b001000,
		ST_EMIT = 6'b010000,
		ST_MARK = 6'b100000
	} tnd_state_t;

	tnd_state_t    state_q;
	logic [7:0]    ch_q;
	logic          last_q;
	logic [LW-1:0] cur_len_q;
	logic [LW-1:0] prev_len_q;
	logic          have_prev_q;
	logic          differs_q;
	logic          cut_q;
	logic          cur_bank_q;
	logic [IW-1:0] idx_q;

	logic          out_valid_q;
	logic [7:0]    out_char_q;
	logic          is_char_q;
	logic          trunc_q;
	logic          out_last_q;

	logic          slot_free;
	logic          fire;
	logic          wr_en;
	logic [IW-1:0] len_addr;
	logic [IW-1:0] emit_raddr;
	logic [IW-1:0] raddr0;
	logic [IW-1:0] raddr1;
	logic [7:0]    rdata0;
	logic [7:0]    rdata1;
	logic [7:0]    cur_rdata;
	logic [7:0]    prev_rdata;
	logic          has_word;
	logic          word_differs;
	logic          idx_is_last;

	assign tok_ready    = (state_q == ST_IDLE);
	assign slot_free    = !out_valid_q || words.ready;
	assign fire         = slot_free &&
		(state_q == ST_SPC || state_q == ST_EMIT || state_q == ST_MARK);
	assign wr_en        = (state_q == ST_CMP) && (cur_len_q < LW'(MAX_WORD));
	assign len_addr     = cur_len_q[IW-1:0];
	// look one entry ahead when a character leaves, so the stream runs at one a cycle while the result slot is free
	assign emit_raddr   = (state_q == ST_EMIT && fire) ? idx_q + IW'(1) : idx_q;
	assign raddr0       = cur_bank_q ? len_addr : emit_raddr;
	assign raddr1       = cur_bank_q ? emit_raddr : len_addr;
	assign cur_rdata    = cur_bank_q ? rdata1 : rdata0;
	assign prev_rdata   = cur_bank_q ? rdata0 : rdata1;
	assign has_word     = (cur_len_q != '0) || cut_q;
	assign word_differs = differs_q || !have_prev_q || (cur_len_q != prev_len_q);
	assign idx_is_last  = (LW'(idx_q) + LW'(1) == cur_len_q);

	tnd_ram #(.WIDTH(8), .DEPTH(MAX_WORD)) u_bank0 (
		.clk   (clk),
		.we    (wr_en && !cur_bank_q),
		.waddr (len_addr),
		.wdata (ch_q),
		.raddr (raddr0),
		.rdata (rdata0)
	);

	tnd_ram #(.WIDTH(8), .DEPTH(MAX_WORD)) u_bank1 (
		.clk   (clk),
		.we    (wr_en && cur_bank_q),
		.waddr (len_addr),
		.wdata (ch_q),
		.raddr (raddr1),
		.rdata (rdata1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= 1'b0;
			cur_len_q   <= '0;
			prev_len_q  <= '0;
			have_prev_q <= 1'b0;
			differs_q   <= 1'b0;
			cut_q       <= 1'b0;
			cur_bank_q  <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (words.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (tok_valid) begin
						last_q <= tok.last;
						case (tok.kind)
							TK_CHAR: state_q <= ST_CMP;
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_CMP: begin
					if (cur_len_q >= LW'(MAX_WORD)) begin
						cut_q <= 1'b1;
					end else begin
						if (!(cur_len_q < prev_len_q && prev_rdata == ch_q)) begin
							differs_q <= 1'b1;
						end
						cur_len_q <= cur_len_q + LW'(1);
					end
					state_q <= last_q ? ST_FIN : ST_IDLE;
				end
				ST_FIN: begin
					if (has_word && word_differs) begin
						state_q <= have_prev_q ? ST_SPC : ST_EMIT;
					end else begin
						// no word, or a repeat of the last one: nothing to send
						cur_len_q <= '0;
						differs_q <= 1'b0;
						cut_q     <= 1'b0;
						state_q   <= last_q ? ST_MARK : ST_IDLE;
					end
				end
				ST_SPC: begin
					if (fire) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (fire) begin
						if (idx_is_last) begin
							idx_q       <= '0;
							cur_bank_q  <= !cur_bank_q;
							prev_len_q  <= last_q ? '0 : cur_len_q;
							have_prev_q <= !last_q;
							cur_len_q   <= '0;
							differs_q   <= 1'b0;
							cut_q       <= 1'b0;
							state_q     <= ST_IDLE;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				ST_MARK: begin
					if (fire) begin
						prev_len_q  <= '0;
						have_prev_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && tok_valid) begin
			ch_q <= tok.ch;
		end
		if (fire) begin
			case (state_q)
				ST_SPC: begin
					out_char_q <= CH_SPACE;
					is_char_q  <= 1'b1;
					trunc_q    <= 1'b0;
					out_last_q <= 1'b0;
				end
				ST_EMIT: begin
					out_char_q <= cur_rdata;
					is_char_q  <= 1'b1;
					trunc_q    <= cut_q;
					out_last_q <= last_q && idx_is_last;
				end
				default: begin
					out_char_q <= CH_NUL;
					is_char_q  <= 1'b0;
					trunc_q    <= 1'b0;
					out_last_q <= 1'b1;
				end
			endcase
		end
	end

	assign words.valid     = out_valid_q;
	assign words.out_char  = out_char_q;
	assign words.is_char   = is_char_q;
	assign words.truncated = trunc_q;
	assign words.out_last  = out_last_q;

endmodule
